// File: src/sha1_message_digest_top_defines.svh
// Assertion macros shared by the SHA-1 digest engine modules.
// Needs clk and rst_n in the scope of each use.
`ifndef SHA1_MESSAGE_DIGEST_TOP_DEFINES_SVH
`define SHA1_MESSAGE_DIGEST_TOP_DEFINES_SVH

// Same-cycle implication, checked outside reset.
`define SHA1MD_ASSERT_NOW(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("sha1md: same-cycle check failed");

// Next-cycle implication, checked outside reset.
`define SHA1MD_ASSERT_NXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("sha1md: next-cycle check failed");

`endif

// File: src/sha1md_pkg.sv
// Shared types and constants of the SHA-1 digest engine.
// No dependencies; imported by the controller, datapath and top level.
package sha1md_pkg;

  localparam int unsigned RND_W = 7;
  localparam logic [RND_W-1:0] LAST_ROUND = 7'd79;
  localparam logic [RND_W-1:0] PHASE1_START = 7'd20;
  localparam logic [RND_W-1:0] PHASE2_START = 7'd40;
  localparam logic [RND_W-1:0] PHASE3_START = 7'd60;

  localparam logic [5:0] FILL_LAST = 6'd63;
  localparam logic [5:0] FILL_LEN_START = 6'd56;
  localparam logic [2:0] LAST_WORD_NUM = 3'd4;

  localparam logic [31:0] H_INIT [5] = '{
    32'h67452301, 32'hEFCDAB89, 32'h98BADCFE, 32'h10325476, 32'hC3D2E1F0
  };

  localparam logic [31:0] K_PH0 = 32'h5A827999;
  localparam logic [31:0] K_PH1 = 32'h6ED9EBA1;
  localparam logic [31:0] K_PH2 = 32'h8F1BBCDC;
  localparam logic [31:0] K_PH3 = 32'hCA62C1D6;

  localparam logic [7:0] PAD_MARK = 8'h80;

  typedef enum logic [1:0] {
    PH_CH  = 2'd0,
    PH_XOR = 2'd1,
    PH_MAJ = 2'd2,
    PH_XR2 = 2'd3
  } phase_t;

  typedef enum logic [1:0] {
    BSEL_IN   = 2'd0,
    BSEL_MARK = 2'd1,
    BSEL_ZERO = 2'd2,
    BSEL_LEN  = 2'd3
  } bsel_t;

  typedef struct packed {
    logic       byte_wr;
    bsel_t      bsel;
    logic       init_work;
    logic       round_en;
    phase_t     phase;
    logic       add_en;
    logic       emit;
    logic [2:0] emit_num;
    logic       reinit;
  } sha1md_cmd_t;

  typedef struct packed {
    logic [5:0] fill;
    logic       out_free;
  } sha1md_stat_t;

endpackage

// File: src/sha1_message_digest_top.sv
// SHA-1 digest engine: one message byte a cycle when in_ready, 5 digest words out.
// Every 64th byte holds input off while the 80 rounds run in one shared round unit
// and the chaining add follows. At end of message the pad bytes are written and
// each padded block compressed; words then go out one a cycle as out_ready allows.
// Reset (rst_n low, synchronous) loads the initial hash, clears count and control;
// the block buffer is not cleared and needs no clearing pass.
module sha1_message_digest_top import sha1md_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [7:0]  in_message_byte,
  input  logic        in_byte_present,
  input  logic        in_end_of_message,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [31:0] out_digest_word,
  output logic [2:0]  out_word_number,
  output logic        out_last_word
);

  // Command and status between the controller and the datapath.
  sha1md_cmd_t  cmd;
  sha1md_stat_t stat;

  // Sequence the word intake, block compression, padding and digest output.
  sha1md_ctrl u_ctrl (
    .clk               (clk),
    .rst_n             (rst_n),
    .in_valid          (in_valid),
    .in_ready          (in_ready),
    .in_byte_present   (in_byte_present),
    .in_end_of_message (in_end_of_message),
    .stat              (stat),
    .cmd               (cmd)
  );

  // Hold the block, run the rounds and register each digest word for output;
  // the result register lets the next message start while a word waits.
  sha1md_datapath u_dp (
    .clk       (clk),
    .rst_n     (rst_n),
    .cmd       (cmd),
    .stat      (stat),
    .in_byte   (in_message_byte),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_word  (out_digest_word),
    .out_num   (out_word_number),
    .out_last  (out_last_word)
  );

endmodule

// File: src/sha1md_datapath.sv
// Datapath of the SHA-1 digest engine: block shift line, round logic,
// chaining words, byte count and result register. Uses sha1md_pkg.
module sha1md_datapath import sha1md_pkg::*; (
  input  logic         clk,
  input  logic         rst_n,
  input  sha1md_cmd_t  cmd,
  output sha1md_stat_t stat,
  input  logic [7:0]   in_byte,
  output logic         out_valid,
  input  logic         out_ready,
  output logic [31:0]  out_word,
  output logic [2:0]   out_num,
  output logic         out_last
);

`include "sha1_message_digest_top_defines.svh"

  // Block buffer doubles as the 16-word schedule window: word 0 is w[t].
  logic [511:0] block_r;
  logic [5:0]   fill_r;
  logic [63:0]  total_r;
  logic [31:0]  h_r [5];
  logic [31:0]  a_r, b_r, c_r, d_r, e_r;
  logic         out_valid_r;
  logic [31:0]  out_word_r;
  logic [2:0]   out_num_r;
  logic         out_last_r;

  logic [31:0]  w_t, w_mix, w_new, f_val, k_val, t_val;
  logic [63:0]  len_bits;
  logic [2:0]   len_idx;
  logic [7:0]   len_byte, wr_byte;

  always_comb begin
    w_t   = block_r[511:480];
    w_mix = block_r[95:64] ^ block_r[255:224] ^ block_r[447:416] ^ block_r[511:480];
    w_new = {w_mix[30:0], w_mix[31]};
    case (cmd.phase)
      PH_CH: begin
        f_val = (b_r & c_r) | (~b_r & d_r);
        k_val = K_PH0;
      end
      PH_XOR: begin
        f_val = b_r ^ c_r ^ d_r;
        k_val = K_PH1;
      end
      PH_MAJ: begin
        f_val = (b_r & c_r) | (b_r & d_r) | (c_r & d_r);
        k_val = K_PH2;
      end
      default: begin
        f_val = b_r ^ c_r ^ d_r;
        k_val = K_PH3;
      end
    endcase
    t_val = {a_r[26:0], a_r[31:27]} + f_val + e_r + k_val + w_t;
  end

  // Length bytes go out most significant first at fill 56..63.
  always_comb begin
    len_bits = {total_r[60:0], 3'b000};
    len_idx  = 3'd7 - fill_r[2:0];
    len_byte = len_bits[{len_idx, 3'b000} +: 8];
    case (cmd.bsel)
      BSEL_IN:   wr_byte = in_byte;
      BSEL_MARK: wr_byte = PAD_MARK;
      BSEL_ZERO: wr_byte = 8'h00;
      BSEL_LEN:  wr_byte = len_byte;
      default:   wr_byte = 8'h00;
    endcase
  end

  always_ff @(posedge clk) begin
    if (cmd.byte_wr) begin
      block_r <= {block_r[503:0], wr_byte};
    end else if (cmd.round_en) begin
      block_r <= {block_r[479:0], w_new};
    end
    if (cmd.init_work) begin
      a_r <= h_r[0];
      b_r <= h_r[1];
      c_r <= h_r[2];
      d_r <= h_r[3];
      e_r <= h_r[4];
    end else if (cmd.round_en) begin
      a_r <= t_val;
      b_r <= a_r;
      c_r <= {b_r[1:0], b_r[31:2]};
      d_r <= c_r;
      e_r <= d_r;
    end
    if (cmd.emit) begin
      out_word_r <= h_r[cmd.emit_num];
      out_num_r  <= cmd.emit_num;
      out_last_r <= (cmd.emit_num == LAST_WORD_NUM);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      fill_r      <= '0;
      total_r     <= '0;
      out_valid_r <= 1'b0;
      for (int i = 0; i < 5; i++) h_r[i] <= H_INIT[i];
    end else begin
      if (cmd.byte_wr) fill_r <= fill_r + 6'd1;
      if (cmd.reinit) begin
        total_r <= '0;
        for (int i = 0; i < 5; i++) h_r[i] <= H_INIT[i];
      end else begin
        if (cmd.byte_wr && (cmd.bsel == BSEL_IN)) total_r <= total_r + 64'd1;
        if (cmd.add_en) begin
          h_r[0] <= h_r[0] + a_r;
          h_r[1] <= h_r[1] + b_r;
          h_r[2] <= h_r[2] + c_r;
          h_r[3] <= h_r[3] + d_r;
          h_r[4] <= h_r[4] + e_r;
        end
      end
      if (cmd.emit) out_valid_r <= 1'b1;
      else if (out_ready) out_valid_r <= 1'b0;
    end
  end

  assign stat.fill     = fill_r;
  assign stat.out_free = !out_valid_r || out_ready;
  assign out_valid     = out_valid_r;
  assign out_word      = out_word_r;
  assign out_num       = out_num_r;
  assign out_last      = out_last_r;

  `SHA1MD_ASSERT_NXT(a_reinit_clears, cmd.reinit, (total_r == '0) && (fill_r == '0))
  `SHA1MD_ASSERT_NOW(a_no_wr_in_round, cmd.round_en, !cmd.byte_wr && !cmd.emit)

endmodule

// File: src/sha1md_ctrl.sv
// Controller of the SHA-1 digest engine: accept, compress, pad, emit.
// Uses sha1md_pkg; drives the datapath through sha1md_cmd_t.
module sha1md_ctrl import sha1md_pkg::*; (
  input  logic         clk,
  input  logic         rst_n,
  input  logic         in_valid,
  output logic         in_ready,
  input  logic         in_byte_present,
  input  logic         in_end_of_message,
  input  sha1md_stat_t stat,
  output sha1md_cmd_t  cmd
);

`include "sha1_message_digest_top_defines.svh"

  typedef enum logic [4:0] {
    ST_IDLE  = 5'b00001,
    ST_COMP  = 5'b00010,
    ST_FINAL = 5'b00100,
    ST_PAD   = 5'b01000,
    ST_EMIT  = 5'b10000
  } state_t;

  state_t           state_r, state_nxt;
  logic [RND_W-1:0] rnd_r, rnd_nxt;
  logic [2:0]       wcnt_r, wcnt_nxt;
  logic             pad_r, pad_nxt;
  logic             first_r, first_nxt;
  logic             len_ok_r, len_ok_nxt;
  logic             eom_pend_r, eom_pend_nxt;
  logic             fill_full;

  assign fill_full = (stat.fill == FILL_LAST);

  always_comb begin
    state_nxt    = state_r;
    rnd_nxt      = rnd_r;
    wcnt_nxt     = wcnt_r;
    pad_nxt      = pad_r;
    first_nxt    = first_r;
    len_ok_nxt   = len_ok_r;
    eom_pend_nxt = eom_pend_r;
    cmd          = '0;
    cmd.bsel     = BSEL_IN;
    cmd.emit_num = wcnt_r;
    in_ready     = 1'b0;
    if (rnd_r < PHASE1_START)      cmd.phase = PH_CH;
    else if (rnd_r < PHASE2_START) cmd.phase = PH_XOR;
    else if (rnd_r < PHASE3_START) cmd.phase = PH_MAJ;
    else                           cmd.phase = PH_XR2;
    case (state_r)
      ST_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.byte_wr = in_byte_present;
          if (in_byte_present && fill_full) begin
            cmd.init_work = 1'b1;
            eom_pend_nxt  = in_end_of_message;
            state_nxt     = ST_COMP;
          end else if (in_end_of_message) begin
            pad_nxt    = 1'b1;
            first_nxt  = 1'b1;
            len_ok_nxt = 1'b0;
            state_nxt  = ST_PAD;
          end
        end
      end
      ST_PAD: begin
        cmd.byte_wr = 1'b1;
        if (first_r) begin
          cmd.bsel   = BSEL_MARK;
          first_nxt  = 1'b0;
          len_ok_nxt = (stat.fill < FILL_LEN_START);
        end else if (len_ok_r && (stat.fill >= FILL_LEN_START)) begin
          cmd.bsel = BSEL_LEN;
        end else begin
          cmd.bsel = BSEL_ZERO;
        end
        if (fill_full) begin
          cmd.init_work = 1'b1;
          state_nxt     = ST_COMP;
        end
      end
      ST_COMP: begin
        cmd.round_en = 1'b1;
        if (rnd_r == LAST_ROUND) begin
          rnd_nxt   = '0;
          state_nxt = ST_FINAL;
        end else begin
          rnd_nxt = rnd_r + 7'd1;
        end
      end
      ST_FINAL: begin
        cmd.add_en = 1'b1;
        if (pad_r) begin
          if (len_ok_r) begin
            wcnt_nxt  = '0;
            state_nxt = ST_EMIT;
          end else begin
            len_ok_nxt = 1'b1;
            state_nxt  = ST_PAD;
          end
        end else if (eom_pend_r) begin
          eom_pend_nxt = 1'b0;
          pad_nxt      = 1'b1;
          first_nxt    = 1'b1;
          len_ok_nxt   = 1'b0;
          state_nxt    = ST_PAD;
        end else begin
          state_nxt = ST_IDLE;
        end
      end
      ST_EMIT: begin
        if (stat.out_free) begin
          cmd.emit = 1'b1;
          if (wcnt_r == LAST_WORD_NUM) begin
            cmd.reinit = 1'b1;
            pad_nxt    = 1'b0;
            state_nxt  = ST_IDLE;
          end else begin
            wcnt_nxt = wcnt_r + 3'd1;
          end
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r    <= ST_IDLE;
      rnd_r      <= '0;
      wcnt_r     <= '0;
      pad_r      <= 1'b0;
      first_r    <= 1'b0;
      len_ok_r   <= 1'b0;
      eom_pend_r <= 1'b0;
    end else begin
      state_r    <= state_nxt;
      rnd_r      <= rnd_nxt;
      wcnt_r     <= wcnt_nxt;
      pad_r      <= pad_nxt;
      first_r    <= first_nxt;
      len_ok_r   <= len_ok_nxt;
      eom_pend_r <= eom_pend_nxt;
    end
  end

  `SHA1MD_ASSERT_NOW(a_rnd_only_comp, rnd_r != '0, state_r == ST_COMP)
  `SHA1MD_ASSERT_NXT(a_last_round, (state_r == ST_COMP) && (rnd_r == LAST_ROUND), state_r == ST_FINAL)
  `SHA1MD_ASSERT_NXT(a_init_then_comp, cmd.init_work, (state_r == ST_COMP) && (rnd_r == '0))
  `SHA1MD_ASSERT_NXT(a_emit_hold, (state_r == ST_EMIT) && !stat.out_free, $stable(wcnt_r))

endmodule

// File: test/tb_top.sv
// Self-checking bench for sha1_message_digest_top: streams message bytes, predicts the
// five digest words of each message with its own SHA-1 model and checks every word.
// Depends on sha1md_pkg and the RTL of the digest engine; nothing else.
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;

  import sha1md_pkg::*;

  // Cycles with no accepted word on either channel before the run is abandoned.
  // The slowest honest gap is a message close needing two padded blocks
  // (pad bytes and rounds for each) plus a stalled receiver.
  localparam int STALL_LIMIT = 3000;
  // Rough count of input words to send before the stimulus stops.
  localparam int WORD_BUDGET = 220;

  typedef struct {
    logic [31:0] word;
    logic [2:0]  num;
    logic        last;
  } digest_word_t;

  logic        clk;
  logic        rst_n;
  logic        in_valid;
  logic        in_ready;
  logic [7:0]  in_message_byte;
  logic        in_byte_present;
  logic        in_end_of_message;
  logic        out_valid;
  logic        out_ready;
  logic [31:0] out_digest_word;
  logic [2:0]  out_word_number;
  logic        out_last_word;

  // Predictor state: chaining words, block buffer and running byte count.
  logic [31:0]  hash_state [5];
  logic [7:0]   block_buf [64];
  logic [63:0]  msg_len_bytes;

  digest_word_t pending_digest [$];
  int           fail_count;
  int           message_words;
  bit           steady_flow;

  sha1_message_digest_top DUT (
    .clk               (clk),
    .rst_n             (rst_n),
    .in_valid          (in_valid),
    .in_ready          (in_ready),
    .in_message_byte   (in_message_byte),
    .in_byte_present   (in_byte_present),
    .in_end_of_message (in_end_of_message),
    .out_valid         (out_valid),
    .out_ready         (out_ready),
    .out_digest_word   (out_digest_word),
    .out_word_number   (out_word_number),
    .out_last_word     (out_last_word)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // ------------------------------------------------------------------
  // SHA-1 predictor
  // ------------------------------------------------------------------

  function automatic void load_initial_hash();
    for (int i = 0; i < 5; i++) hash_state[i] = H_INIT[i];
    msg_len_bytes = '0;
  endfunction

  // Run the 80 rounds over block_buf and fold the result into hash_state.
  function automatic void run_rounds();
    logic [31:0] w [80];
    logic [31:0] a, b, c, d, e, f, k, t;
    for (int i = 0; i < 16; i++)
      w[i] = {block_buf[4*i], block_buf[4*i+1], block_buf[4*i+2], block_buf[4*i+3]};
    for (int i = 16; i < 80; i++) begin
      t = w[i-3] ^ w[i-8] ^ w[i-14] ^ w[i-16];
      w[i] = {t[30:0], t[31]};
    end
    a = hash_state[0];
    b = hash_state[1];
    c = hash_state[2];
    d = hash_state[3];
    e = hash_state[4];
    for (int i = 0; i < 80; i++) begin
      if (i < PHASE1_START) begin
        f = (b & c) | (~b & d);
        k = K_PH0;
      end else if (i < PHASE2_START) begin
        f = b ^ c ^ d;
        k = K_PH1;
      end else if (i < PHASE3_START) begin
        f = (b & c) | (b & d) | (c & d);
        k = K_PH2;
      end else begin
        f = b ^ c ^ d;
        k = K_PH3;
      end
      t = {a[26:0], a[31:27]} + f + e + k + w[i];
      e = d;
      d = c;
      c = {b[1:0], b[31:2]};
      b = a;
      a = t;
    end
    hash_state[0] += a;
    hash_state[1] += b;
    hash_state[2] += c;
    hash_state[3] += d;
    hash_state[4] += e;
  endfunction

  function automatic void absorb_byte(input logic [7:0] data);
    int pos;
    pos = msg_len_bytes[5:0];
    block_buf[pos] = data;
    msg_len_bytes += 64'd1;
    if (pos == FILL_LAST) run_rounds();
  endfunction

  // Pad, append the bit length, queue the five digest words and reload the initial hash.
  function automatic void close_message();
    logic [63:0]  bit_len;
    int           pos;
    digest_word_t dw;
    bit_len = msg_len_bytes << 3;
    pos = msg_len_bytes[5:0];
    block_buf[pos] = PAD_MARK;
    pos++;
    if (pos > FILL_LEN_START) begin
      while (pos < 64) begin
        block_buf[pos] = 8'h00;
        pos++;
      end
      run_rounds();
      pos = 0;
    end
    while (pos < FILL_LEN_START) begin
      block_buf[pos] = 8'h00;
      pos++;
    end
    for (int i = 0; i < 8; i++) block_buf[56+i] = bit_len[63-8*i -: 8];
    run_rounds();
    for (int i = 0; i < 5; i++) begin
      dw.word = hash_state[i];
      dw.num  = i[2:0];
      dw.last = (i[2:0] == LAST_WORD_NUM);
      pending_digest.push_back(dw);
    end
    load_initial_hash();
  endfunction

  function automatic void predict_word(input logic [7:0] data, input logic has_byte,
                                       input logic closes);
    if (has_byte) absorb_byte(data);
    if (closes) close_message();
  endfunction

  // ------------------------------------------------------------------
  // Driving
  // ------------------------------------------------------------------

  // Enter and leave at a falling edge. Idle at random first (never in steady flow),
  // then hold the word until the engine takes it, and advance the predictor on acceptance.
  task automatic send_word(input logic [7:0] data, input logic has_byte,
                           input logic closes);
    while (!steady_flow && $urandom_range(99) < 22) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    in_valid          <= 1'b1;
    in_message_byte   <= data;
    in_byte_present   <= has_byte;
    in_end_of_message <= closes;
    do @(posedge clk); while (!in_ready);
    predict_word(data, has_byte, closes);
    message_words++;
    @(negedge clk);
  endtask

  // Random content of the given length; close either on the last byte or with a
  // separate end word. Noisy messages carry the odd empty word in between.
  task automatic send_message(input int unsigned len, input bit noisy);
    bit end_on_byte;
    end_on_byte = (len != 0) && ($urandom_range(1) == 1);
    for (int unsigned n = 0; n < len; n++) begin
      if (noisy && $urandom_range(11) == 0) send_word(8'($urandom_range(255)), 1'b0, 1'b0);
      send_word(8'($urandom_range(255)), 1'b1, end_on_byte && (n == len - 1));
    end
    if (!end_on_byte) begin
      send_word(8'($urandom_range(255)), 1'b0, 1'b1);
    end
  endtask

  // Drop valid and hold off until every predicted digest word has come back.
  task automatic wait_for_digests();
    in_valid <= 1'b0;
    while (pending_digest.size() != 0) @(negedge clk);
  endtask

  // Receiver: stall at random, about 22 percent of the time, never during steady flow.
  always @(negedge clk) begin
    out_ready <= steady_flow || ($urandom_range(99) >= 22);
  end

  // ------------------------------------------------------------------
  // Checking
  // ------------------------------------------------------------------

  always @(posedge clk) begin
    digest_word_t want;
    if (rst_n && out_valid && out_ready) begin
      if (pending_digest.size() == 0) begin
        fail_count++;
        if (fail_count <= 10)
          $display("unexpected digest word %h number %0d last %0b",
                   out_digest_word, out_word_number, out_last_word);
      end else begin
        want = pending_digest.pop_front();
        if (want.word !== out_digest_word || want.num !== out_word_number ||
            want.last !== out_last_word) begin
          fail_count++;
          if (fail_count <= 10)
            $display("digest mismatch: expected %h/%0d/%0b, got %h/%0d/%0b",
                     want.word, want.num, want.last,
                     out_digest_word, out_word_number, out_last_word);
        end
      end
    end
  end

  // Watchdog: count cycles without any accepted word on either channel.
  initial begin
    int quiet;
    quiet = 0;
    while (quiet < STALL_LIMIT) begin
      @(posedge clk);
      if (!rst_n || (in_valid && in_ready) || (out_valid && out_ready)) quiet = 0;
      else quiet++;
    end
    $display("sha1_message_digest_top verification failed");
    $finish;
  end

  // ------------------------------------------------------------------
  // Tests
  // ------------------------------------------------------------------

  // End word with no byte at all: digest of the empty string.
  task automatic test_empty_message();
    send_word(8'h5A, 1'b0, 1'b1);
  endtask

  // One-byte messages at both byte extremes, byte and end in the same word,
  // then a three-byte message closed by a separate end word.
  task automatic test_short_messages();
    send_word(8'h00, 1'b1, 1'b1);
    send_word(8'hFF, 1'b1, 1'b1);
    send_word(8'h61, 1'b1, 1'b0);
    send_word(8'h62, 1'b1, 1'b0);
    send_word(8'h63, 1'b1, 1'b0);
    send_word(8'hA5, 1'b0, 1'b1);
  endtask

  // Words with neither byte nor end must change nothing, including mid-message.
  task automatic test_ignored_words();
    send_word(8'hFF, 1'b0, 1'b0);
    send_word(8'h12, 1'b1, 1'b0);
    send_word(8'h00, 1'b0, 1'b0);
    send_word(8'hC3, 1'b0, 1'b0);
    send_word(8'h34, 1'b1, 1'b1);
    send_word(8'h00, 1'b0, 1'b1);
  endtask

  // 55 bytes fit the length in one padded block; 56 force a second block.
  task automatic test_pad_boundaries();
    send_message(55, 1'b0);
    send_message(56, 1'b1);
  endtask

  // Pause the sender until the engine has drained, then carry on mid-stream.
  task automatic test_drain_pause();
    send_message(9, 1'b0);
    wait_for_digests();
    send_message(4, 1'b0);
    wait_for_digests();
  endtask

  // A long stretch with no idling on either side: a full block, then a short one.
  task automatic test_steady_flow();
    steady_flow = 1'b1;
    send_message(64, 1'b0);
    send_message(7, 1'b0);
    steady_flow = 1'b0;
  endtask

  // Mostly short messages, the odd one near a block boundary, noise words mixed in.
  task automatic test_random_messages();
    int unsigned len;
    while (message_words < WORD_BUDGET) begin
      if ($urandom_range(9) == 0) len = $urandom_range(50, 70);
      else len = $urandom_range(0, 12);
      send_message(len, 1'b1);
      if ($urandom_range(7) == 0) wait_for_digests();
    end
  endtask

  task automatic finish_run();
    in_valid <= 1'b0;
    while (pending_digest.size() != 0) @(posedge clk);
    repeat (100) @(posedge clk);
    fail_count += pending_digest.size();
    if (fail_count == 0)
      $display("sha1_message_digest_top verification clean");
    else
      $display("sha1_message_digest_top verification failed");
    $finish;
  endtask

  initial begin
    rst_n             = 1'b0;
    in_valid          = 1'b0;
    in_message_byte   = 8'h00;
    in_byte_present   = 1'b0;
    in_end_of_message = 1'b0;
    out_ready         = 1'b0;
    steady_flow       = 1'b0;
    fail_count        = 0;
    message_words     = 0;
    foreach (block_buf[i]) block_buf[i] = 8'h00;
    load_initial_hash();
    repeat (4) @(negedge clk);
    rst_n <= 1'b1;
    test_empty_message();
    test_short_messages();
    test_ignored_words();
    test_pad_boundaries();
    test_drain_pause();
    test_steady_flow();
    test_random_messages();
    finish_run();
  end

endmodule
